### sv/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants for the LRU column cache budget block.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int IDX_W   = 5;
    localparam int LEN_W   = 16;
    localparam int ALLOC_W = 17;
    localparam int RANK_W  = 6;
    localparam int FREE_W  = 24;
    localparam int KIND_W  = 2;

    localparam int DEF_NUM_ENTRIES = 32;
    localparam int DEF_CHUNK_SLACK = 64;

    localparam logic [FREE_W-1:0] CAP_RESET = FREE_W'(1048576);
    localparam logic [FREE_W-1:0] FREE_MAX  = {FREE_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_EVICT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOSPACE = 2'd2;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_UNLIST,
        CMD_EVICT,
        CMD_SETALLOC,
        CMD_CLEAR,
        CMD_LIST
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   idx;
        logic [RANK_W-1:0]  rank;
        logic [ALLOC_W-1:0] alloc;
        logic [LEN_W-1:0]   len;
    } t_cmd;

    typedef struct packed {
        logic               sel_listed;
        logic [RANK_W-1:0]  sel_rank;
        logic [ALLOC_W-1:0] sel_alloc;
        logic [LEN_W-1:0]   sel_cached;
        logic               vic_hit;
        logic [IDX_W-1:0]   vic_idx;
        logic [ALLOC_W-1:0] vic_alloc;
    } t_tap;

endpackage

### sv/lcc_if.sv
// ----------------------------------------------------------------------------
// lcc_if
// Valid/ready channels: request, response and configuration words.
// ----------------------------------------------------------------------------
interface lcc_req_if;
    logic                        valid;
    logic                        ready;
    logic [lcc_pkg::IDX_W-1:0]   entry_index;
    logic [lcc_pkg::LEN_W-1:0]   request_length;
    modport source (output valid, entry_index, request_length, input ready);
    modport sink   (input valid, entry_index, request_length, output ready);
endinterface

interface lcc_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [lcc_pkg::KIND_W-1:0]  kind;
    logic [lcc_pkg::IDX_W-1:0]   affected_index;
    logic [lcc_pkg::LEN_W-1:0]   prev_length;
    logic                        is_last;
    modport source (output valid, kind, affected_index, prev_length, is_last,
                    input ready);
    modport sink   (input valid, kind, affected_index, prev_length, is_last,
                    output ready);
endinterface

interface lcc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lcc_pkg::FREE_W-1:0]  data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### sv/lcc_cell.sv
// ----------------------------------------------------------------------------
// lcc_cell
// One cache entry: lengths, LRU rank and list flag; joins the lookup chain.
// ----------------------------------------------------------------------------
module lcc_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lcc_pkg::t_cmd               i_cmd,
    input  logic [lcc_pkg::IDX_W-1:0]   i_look_idx,
    input  lcc_pkg::t_tap               i_tap,
    output lcc_pkg::t_tap               o_tap
);

    logic [lcc_pkg::LEN_W-1:0]   r_cached, n_cached;
    logic [lcc_pkg::ALLOC_W-1:0] r_alloc,  n_alloc;
    logic [lcc_pkg::RANK_W-1:0]  r_rank,   n_rank;
    logic                        r_listed, n_listed;
    logic                        hit;
    logic                        look;
    logic                        vic;

    assign hit  = (32'(i_cmd.idx) == CELL_ID);
    assign look = (32'(i_look_idx) == CELL_ID);
    assign vic  = r_listed && (r_rank == '0);

    always_comb begin
        n_cached = r_cached;
        n_alloc  = r_alloc;
        n_rank   = r_rank;
        n_listed = r_listed;
        case (i_cmd.op)
            lcc_pkg::CMD_UNLIST, lcc_pkg::CMD_EVICT: begin
                if (hit) begin
                    n_listed = 1'b0;
                    n_rank   = '0;
                    if (i_cmd.op == lcc_pkg::CMD_EVICT) begin
                        n_alloc  = '0;
                        n_cached = '0;
                    end
                end else if (r_listed && r_rank > i_cmd.rank) begin
                    n_rank = r_rank - 1'b1;
                end
            end
            lcc_pkg::CMD_SETALLOC: begin
                if (hit) n_alloc = i_cmd.alloc;
            end
            lcc_pkg::CMD_CLEAR: begin
                if (hit) begin
                    n_alloc  = '0;
                    n_cached = '0;
                end
            end
            lcc_pkg::CMD_LIST: begin
                if (hit) begin
                    n_listed = 1'b1;
                    n_rank   = i_cmd.rank;
                    n_cached = i_cmd.len;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cached <= '0;
            r_alloc  <= '0;
            r_rank   <= '0;
            r_listed <= 1'b0;
        end else begin
            r_cached <= n_cached;
            r_alloc  <= n_alloc;
            r_rank   <= n_rank;
            r_listed <= n_listed;
        end
    end

    always_comb begin
        o_tap = i_tap;
        if (look) begin
            o_tap.sel_listed = i_tap.sel_listed | r_listed;
            o_tap.sel_rank   = i_tap.sel_rank   | r_rank;
            o_tap.sel_alloc  = i_tap.sel_alloc  | r_alloc;
            o_tap.sel_cached = i_tap.sel_cached | r_cached;
        end
        if (vic) begin
            o_tap.vic_hit   = 1'b1;
            o_tap.vic_idx   = i_tap.vic_idx   | lcc_pkg::IDX_W'(CELL_ID);
            o_tap.vic_alloc = i_tap.vic_alloc | r_alloc;
        end
    end

endmodule

### sv/lru_column_cache_budget_top.sv
// ----------------------------------------------------------------------------
// lru_column_cache_budget_top
// LRU column cache bookkeeping with a free-space budget and evictions.
// ----------------------------------------------------------------------------
// A request steps through lookup, unlist, list and back to idle when its
// allocation does not grow. When the allocation grows, a budget check comes
// before the list step, and each eviction is issued from the budget check.
// An out-of-space request ends at the budget check, or at the lookup if its
// index is out of range. A response word that waits on the receiver stalls
// the request until it is taken. One request is in flight at a time, and each
// result word is held in an output register until taken. Every entry lives
// in its own cell of a chain. The cells are updated by a broadcast command
// and report the selected entry and the least recent entry along the chain.
// Writing the config word loads the free-space budget.
module lru_column_cache_budget_top #(
    parameter int NUM_ENTRIES = lcc_pkg::DEF_NUM_ENTRIES,
    parameter int CHUNK_SLACK = lcc_pkg::DEF_CHUNK_SLACK
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lcc_req_if.sink    i_req,
    lcc_rsp_if.source  o_rsp,
    lcc_cfg_if.sink    i_cfg
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOOK   = 3'd1;
    localparam logic [2:0] S_UNLIST = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]                        r_state, n_state;
    logic [lcc_pkg::IDX_W-1:0]         r_idx;
    logic [lcc_pkg::LEN_W-1:0]         r_len;
    logic [lcc_pkg::ALLOC_W-1:0]       r_alloc;
    logic [lcc_pkg::LEN_W-1:0]         r_cached;
    logic [lcc_pkg::RANK_W-1:0]        r_erank;
    logic                              r_elisted;
    logic [lcc_pkg::ALLOC_W-1:0]       r_target;
    logic [lcc_pkg::ALLOC_W-1:0]       r_more;
    logic [lcc_pkg::RANK_W-1:0]        r_count, n_count;
    logic [lcc_pkg::FREE_W-1:0]        r_free, n_free;

    logic                              r_ovalid;
    logic [lcc_pkg::KIND_W-1:0]        r_okind;
    logic [lcc_pkg::IDX_W-1:0]         r_oidx;
    logic [lcc_pkg::LEN_W-1:0]         r_oprev;
    logic                              r_olast;

    logic                              emit;
    logic [lcc_pkg::KIND_W-1:0]        e_kind;
    logic [lcc_pkg::IDX_W-1:0]         e_idx;
    logic [lcc_pkg::LEN_W-1:0]         e_prev;
    logic                              out_free;
    logic                              req_acc;
    logic                              bad_idx;
    logic                              grow;
    logic [lcc_pkg::ALLOC_W-1:0]       target;
    logic [lcc_pkg::FREE_W:0]          sum_e;
    logic [lcc_pkg::FREE_W:0]          sum_v;

    lcc_pkg::t_cmd                     cmd;
    lcc_pkg::t_tap                     tap [NUM_ENTRIES+1];

    assign tap[0]   = '0;
    assign out_free = !r_ovalid || o_rsp.ready;
    assign req_acc  = i_req.valid && i_req.ready;
    assign bad_idx  = 32'(r_idx) >= NUM_ENTRIES;
    assign grow     = lcc_pkg::ALLOC_W'(r_len) > r_alloc;
    assign target   = lcc_pkg::ALLOC_W'(r_len) + lcc_pkg::ALLOC_W'(CHUNK_SLACK);
    assign sum_e    = {1'b0, r_free} + (lcc_pkg::FREE_W+1)'(r_alloc);
    assign sum_v    = {1'b0, r_free} + (lcc_pkg::FREE_W+1)'(tap[NUM_ENTRIES].vic_alloc);

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);

    genvar g;
    generate
        for (g = 0; g < NUM_ENTRIES; g++) begin : g_cell
            lcc_cell #(.CELL_ID(g)) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (cmd),
                .i_look_idx (r_idx),
                .i_tap      (tap[g]),
                .o_tap      (tap[g+1])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_free  = r_free;
        cmd     = '0;
        cmd.op  = lcc_pkg::CMD_NONE;
        emit    = 1'b0;
        e_kind  = lcc_pkg::KIND_DONE;
        e_idx   = r_idx;
        e_prev  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cfg.valid) n_free = i_cfg.data;
                if (req_acc) n_state = S_LOOK;
            end
            S_LOOK: begin
                if (bad_idx) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        e_kind  = lcc_pkg::KIND_NOSPACE;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_UNLIST;
                end
            end
            S_UNLIST: begin
                if (r_elisted) begin
                    cmd.op   = lcc_pkg::CMD_UNLIST;
                    cmd.idx  = r_idx;
                    cmd.rank = r_erank;
                    n_count  = r_count - 1'b1;
                end
                n_state = grow ? S_CHECK : S_DONE;
            end
            S_CHECK: begin
                if (r_free >= lcc_pkg::FREE_W'(r_more)) begin
                    n_free    = r_free - lcc_pkg::FREE_W'(r_more);
                    cmd.op    = lcc_pkg::CMD_SETALLOC;
                    cmd.idx   = r_idx;
                    cmd.alloc = r_target;
                    n_state   = S_DONE;
                end else if (out_free) begin
                    emit = 1'b1;
                    if (tap[NUM_ENTRIES].vic_hit) begin
                        e_kind   = lcc_pkg::KIND_EVICT;
                        e_idx    = tap[NUM_ENTRIES].vic_idx;
                        cmd.op   = lcc_pkg::CMD_EVICT;
                        cmd.idx  = tap[NUM_ENTRIES].vic_idx;
                        n_count  = r_count - 1'b1;
                        n_free   = sum_v[lcc_pkg::FREE_W] ? lcc_pkg::FREE_MAX
                                                          : sum_v[lcc_pkg::FREE_W-1:0];
                    end else begin
                        e_kind  = lcc_pkg::KIND_NOSPACE;
                        cmd.op  = lcc_pkg::CMD_CLEAR;
                        cmd.idx = r_idx;
                        n_free  = sum_e[lcc_pkg::FREE_W] ? lcc_pkg::FREE_MAX
                                                         : sum_e[lcc_pkg::FREE_W-1:0];
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_kind   = lcc_pkg::KIND_DONE;
                    e_prev   = r_cached;
                    cmd.op   = lcc_pkg::CMD_LIST;
                    cmd.idx  = r_idx;
                    cmd.rank = r_count;
                    cmd.len  = r_len;
                    n_count  = r_count + 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_free   <= lcc_pkg::CAP_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_free  <= n_free;
            if (emit)             r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_idx <= i_req.entry_index;
            r_len <= i_req.request_length;
        end
        if (r_state == S_LOOK) begin
            r_alloc   <= tap[NUM_ENTRIES].sel_alloc;
            r_cached  <= tap[NUM_ENTRIES].sel_cached;
            r_erank   <= tap[NUM_ENTRIES].sel_rank;
            r_elisted <= tap[NUM_ENTRIES].sel_listed;
        end
        if (r_state == S_UNLIST) begin
            r_target <= target;
            r_more   <= target - r_alloc;
        end
        if (emit) begin
            r_okind <= e_kind;
            r_oidx  <= e_idx;
            r_oprev <= e_prev;
            r_olast <= (e_kind != lcc_pkg::KIND_EVICT);
        end
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.kind           = r_okind;
    assign o_rsp.affected_index = r_oidx;
    assign o_rsp.prev_length    = r_oprev;
    assign o_rsp.is_last        = r_olast;

endmodule

### sv/lcc_checker.sv
// ----------------------------------------------------------------------------
// lcc_checker
// Port-level checks on the request and response channels.
// ----------------------------------------------------------------------------
module lcc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic [lcc_pkg::KIND_W-1:0]  i_rsp_kind,
    input logic [lcc_pkg::LEN_W-1:0]   i_rsp_prev,
    input logic                        i_rsp_last
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response word dropped while stalled");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_last == (i_rsp_kind != lcc_pkg::KIND_EVICT)))
        else $error("is_last does not match word kind");

    a_prev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_kind != lcc_pkg::KIND_DONE) |-> (i_rsp_prev == '0))
        else $error("prev_length set on eviction or out-of-space word");

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

endmodule

bind lru_column_cache_budget_top lcc_checker u_lcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_kind  (o_rsp.kind),
    .i_rsp_prev  (o_rsp.prev_length),
    .i_rsp_last  (o_rsp.is_last)
);

### test/lru_column_cache_budget_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_column_cache_budget_top_tb
// Self-checking bench for the LRU column cache budget block: requests go in
// with random gaps, result words are checked in order against a behavioral
// model of entry lengths, LRU order and the free-space budget, over several
// capacity settings including zero and full scale.
// ----------------------------------------------------------------------------
module lru_column_cache_budget_top_tb;

    localparam int NENT       = lcc_pkg::DEF_NUM_ENTRIES;
    localparam int SLACK      = lcc_pkg::DEF_CHUNK_SLACK;
    localparam int CYCLE_MAX  = 600000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 80;

    typedef struct packed {
        logic [lcc_pkg::KIND_W-1:0] kind;
        logic [lcc_pkg::IDX_W-1:0]  idx;
        logic [lcc_pkg::LEN_W-1:0]  prev;
        logic                       last;
    } t_word;

    class cache_scoreboard;
        int unsigned capacity;
        int unsigned free_sp;
        int unsigned cached[NENT];
        int unsigned alloc[NENT];
        int unsigned rank[NENT];
        bit          listed[NENT];
        t_word       pending[$];
        int          errors;
        int          n_words;
        int          n_evict;
        int          n_nospace;

        function new();
            capacity = lcc_pkg::CAP_RESET;
            free_sp  = lcc_pkg::CAP_RESET;
            foreach (cached[i]) begin
                cached[i] = 0;
                alloc[i]  = 0;
                rank[i]   = 0;
                listed[i] = 0;
            end
        endfunction

        function void set_capacity(int unsigned v);
            capacity = v;
            free_sp  = v;
        endfunction

        function void drop(int unsigned e);
            if (!listed[e]) return;
            foreach (rank[i])
                if (listed[i] && rank[i] > rank[e]) rank[i]--;
            listed[e] = 0;
            rank[e]   = 0;
        endfunction

        function void give_back(int unsigned amt);
            free_sp = (free_sp + amt > lcc_pkg::FREE_MAX) ? lcc_pkg::FREE_MAX
                                                          : free_sp + amt;
        endfunction

        function void push(logic [lcc_pkg::KIND_W-1:0] k, int unsigned e,
                           int unsigned p, bit l);
            t_word w;
            w.kind = k;
            w.idx  = lcc_pkg::IDX_W'(e);
            w.prev = lcc_pkg::LEN_W'(p);
            w.last = l;
            pending.push_back(w);
        endfunction

        function void note_request(int unsigned e, int unsigned len);
            int unsigned target;
            int unsigned more;
            int          victim;
            int          cnt;
            drop(e);
            if (len > alloc[e]) begin
                target = len + SLACK;
                more   = target - alloc[e];
                while (free_sp < more) begin
                    victim = -1;
                    foreach (listed[i])
                        if (listed[i] && rank[i] == 0) victim = i;
                    if (victim < 0) begin
                        give_back(alloc[e]);
                        alloc[e]  = 0;
                        cached[e] = 0;
                        push(lcc_pkg::KIND_NOSPACE, e, 0, 1);
                        return;
                    end
                    drop(victim);
                    give_back(alloc[victim]);
                    alloc[victim]  = 0;
                    cached[victim] = 0;
                    push(lcc_pkg::KIND_EVICT, victim, 0, 0);
                end
                free_sp -= more;
                alloc[e] = target;
            end
            cnt = 0;
            foreach (listed[i]) if (listed[i]) cnt++;
            rank[e]   = cnt;
            listed[e] = 1;
            push(lcc_pkg::KIND_DONE, e, cached[e], 1);
            cached[e] = len;
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_word(t_word got);
            t_word exp;
            n_words++;
            if (got.kind == lcc_pkg::KIND_EVICT) n_evict++;
            if (got.kind == lcc_pkg::KIND_NOSPACE) n_nospace++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word kind=%0d idx=%0d", got.kind, got.idx));
                return;
            end
            exp = pending.pop_front();
            if (got.kind != exp.kind)
                report($sformatf("kind %0d, want %0d", got.kind, exp.kind));
            if (got.idx != exp.idx)
                report($sformatf("affected_index %0d, want %0d", got.idx, exp.idx));
            if (got.prev != exp.prev)
                report($sformatf("prev_length %0d, want %0d", got.prev, exp.prev));
            if (got.last != exp.last)
                report($sformatf("is_last %0d, want %0d", got.last, exp.last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_en;
    bit   hold_go;
    bit   hold_done = 0;
    int   hold_left = 0;
    int   cycles = 0;
    int   n_req;
    cache_scoreboard sb;

    lcc_req_if req_if();
    lcc_rsp_if rsp_if();
    lcc_cfg_if cfg_if();

    lru_column_cache_budget_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycles);
            $display("lru_column_cache_budget_top verification failed");
            $finish;
        end
    end

    // response sink; a long hold-off fills the block and stalls its input
    initial begin
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready = 1'b0;
            end else begin
                rsp_if.ready = !(idle_en && $urandom_range(99) < 32);
            end
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_word({rsp_if.kind, rsp_if.affected_index,
                               rsp_if.prev_length, rsp_if.is_last});
        end
    end

    task send_req(int unsigned e, int unsigned len);
        while (idle_en && $urandom_range(99) < 32) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid          = 1'b1;
        req_if.entry_index    = lcc_pkg::IDX_W'(e);
        req_if.request_length = lcc_pkg::LEN_W'(len);
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(e, len);
        n_req++;
        @(negedge i_clk);
    endtask

    task drain();
        req_if.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task write_cap(int unsigned v);
        drain();
        cfg_if.valid = 1'b1;
        cfg_if.data  = lcc_pkg::FREE_W'(v);
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.set_capacity(v);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function int unsigned pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(1, 200);
        if (r < 85) return $urandom_range(1, 4000);
        return $urandom_range(1, 65535);
    endfunction

    task random_phase(int unsigned cap, int n, bit narrow);
        write_cap(cap);
        repeat (n) begin
            if (narrow) send_req($urandom_range(0, 7), pick_len());
            else send_req($urandom_range(0, NENT - 1), pick_len());
        end
    endtask

    initial begin
        sb        = new();
        idle_en   = 1;
        hold_go   = 0;
        n_req     = 0;
        i_rst_n   = 1'b0;
        req_if.valid          = 1'b0;
        req_if.entry_index    = '0;
        req_if.request_length = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: growth, re-request, zero length, no growth
        send_req(0, 1);
        send_req(31, 65535);
        send_req(0, 65535);
        send_req(0, 0);
        send_req(31, 10);
        send_req(16, 21845);
        send_req(15, 43690);
        // zero budget: evictions then out of space
        write_cap(0);
        send_req(5, 1);
        send_req(7, 65535);
        send_req(7, 3);
        // tiny budget: evict one, then run dry
        write_cap(200);
        send_req(1, 100);
        send_req(2, 100);
        send_req(3, 200);
        send_req(2, 50);
        write_cap(lcc_pkg::FREE_MAX);
        send_req(9, 65535);
        send_req(9, 65535);

        random_phase($urandom_range(200, 3000), 45, 1);
        // receiver holds off while requests keep coming
        write_cap($urandom_range(20000, 200000));
        hold_go = 1;
        repeat (45) send_req($urandom_range(0, NENT - 1), pick_len());
        idle_en = 0;
        random_phase($urandom_range(300, 6000), 40, 0);
        idle_en = 1;
        random_phase(0, 15, 1);
        random_phase(lcc_pkg::FREE_MAX, 30, 0);
        random_phase(lcc_pkg::CAP_RESET, 30, 0);
        // shrink budget under live allocations
        write_cap(65000);
        repeat (10) send_req($urandom_range(0, NENT - 1), $urandom_range(1, 65535));

        drain();
        $display("%0d requests, %0d result words (%0d evictions, %0d out of space)",
                 n_req, sb.n_words, sb.n_evict, sb.n_nospace);
        $display("budgets covered: zero, tiny, random, 1M and full scale");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("lru_column_cache_budget_top verification clean");
        end else begin
            $display("%0d mismatches, %0d words missing", sb.errors, sb.pending.size());
            $display("lru_column_cache_budget_top verification failed");
        end
        $finish;
    end
endmodule
